/* hw/rtl/blr_pkg.sv */
// shared types, constants and helpers of the line rasterizer
`timescale 1ns / 1ps

package blr_pkg;

  localparam int SCREEN_WIDTH  = 256;
  localparam int SCREEN_HEIGHT = 64;

  localparam int XW   = 8;
  localparam int YW   = 6;
  localparam int CW   = 4;
  localparam int ERRW = 10;

  // item kinds
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  // one queue entry, load fields already worked out by the front part
  typedef struct packed {
    logic            func;
    logic [XW-1:0]   x0;
    logic [YW-1:0]   y0;
    logic [XW-1:0]   x1;
    logic [YW-1:0]   y1;
    logic [XW-1:0]   span_x;
    logic [YW-1:0]   span_y;
    logic            neg_x;
    logic            neg_y;
    logic [ERRW-1:0] err;
    logic [CW-1:0]   color;
    logic            show;
  } cmd_t;

  // head of the queue as seen by the back part
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } head_t;

  function automatic logic [XW-1:0] clamp_x(logic [XW-1:0] v);
    logic [XW-1:0] r;
    r = v;
    if (int'(v) > SCREEN_WIDTH - 1) r = XW'(SCREEN_WIDTH - 1);
    return r;
  endfunction

  function automatic logic [YW-1:0] clamp_y(logic [YW-1:0] v);
    logic [YW-1:0] r;
    r = v;
    if (int'(v) > SCREEN_HEIGHT - 1) r = YW'(SCREEN_HEIGHT - 1);
    return r;
  endfunction

endpackage

/* hw/rtl/blr_if.sv */
// valid/ready channel interfaces for items and pixels
`timescale 1ns / 1ps

interface blr_item_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] x_start;
  logic [5:0] y_start;
  logic [7:0] x_end;
  logic [5:0] y_end;
  logic [3:0] pen_color;
  logic       show_now;

  modport source (output valid, func, x_start, y_start, x_end, y_end, pen_color, show_now,
                  input ready);
  modport sink (input valid, func, x_start, y_start, x_end, y_end, pen_color, show_now,
                output ready);
endinterface

interface blr_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_x;
  logic [5:0] pixel_y;
  logic [3:0] pixel_color;
  logic       pixel_show_now;
  logic       last;

  modport source (output valid, pixel_x, pixel_y, pixel_color, pixel_show_now, last,
                  input ready);
  modport sink (input valid, pixel_x, pixel_y, pixel_color, pixel_show_now, last,
                output ready);
endinterface

/* hw/rtl/blr_front.sv */
// front part: accepts items, precomputes line setup, two-entry queue
`timescale 1ns / 1ps

module blr_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  blr_item_if.sink         item_i,
  input  logic             pop_i,
  output blr_pkg::head_t   head_o
);

  blr_pkg::cmd_t cmd_in;
  blr_pkg::cmd_t mem_q [2];
  logic          wr_ptr_q, wr_ptr_d;
  logic          rd_ptr_q, rd_ptr_d;
  logic [1:0]    count_q, count_d;
  logic          push;
  logic          pop;

  logic [blr_pkg::XW-1:0] x0, x1, sx;
  logic [blr_pkg::YW-1:0] y0, y1, sy;

  // line setup
  always_comb begin
    x0 = blr_pkg::clamp_x(item_i.x_start);
    y0 = blr_pkg::clamp_y(item_i.y_start);
    x1 = blr_pkg::clamp_x(item_i.x_end);
    y1 = blr_pkg::clamp_y(item_i.y_end);
    sx = (x1 >= x0) ? x1 - x0 : x0 - x1;
    sy = (y1 >= y0) ? y1 - y0 : y0 - y1;

    cmd_in.func   = item_i.func;
    cmd_in.x0     = x0;
    cmd_in.y0     = y0;
    cmd_in.x1     = x1;
    cmd_in.y1     = y1;
    cmd_in.span_x = sx;
    cmd_in.span_y = sy;
    cmd_in.neg_x  = !(x0 < x1);
    cmd_in.neg_y  = !(y0 < y1);
    if ({1'b0, sx} > {{(blr_pkg::XW - blr_pkg::YW + 1){1'b0}}, sy}) begin
      cmd_in.err = blr_pkg::ERRW'(sx >> 1);
    end else begin
      cmd_in.err = blr_pkg::ERRW'(0) - blr_pkg::ERRW'(sy >> 1);
    end
    cmd_in.color = item_i.pen_color;
    cmd_in.show  = item_i.show_now;
  end

  assign item_i.ready = (count_q != 2'd2);
  assign push         = item_i.valid && item_i.ready;
  assign pop          = pop_i && (count_q != 2'd0);

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= cmd_in;
    end
  end

  assign head_o.valid = (count_q != 2'd0);
  assign head_o.cmd   = mem_q[rd_ptr_q];

endmodule

/* hw/rtl/blr_back.sv */
// back part: bresenham stepping and the pixel output register
`timescale 1ns / 1ps

module blr_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  blr_pkg::head_t head_i,
  output logic           pop_o,
  blr_pixel_if.source    pixel_o
);

  logic [blr_pkg::XW-1:0]   cur_x_q, cur_x_d, goal_x_q, goal_x_d, span_x_q, span_x_d;
  logic [blr_pkg::YW-1:0]   cur_y_q, cur_y_d, goal_y_q, goal_y_d, span_y_q, span_y_d;
  logic                     neg_x_q, neg_x_d, neg_y_q, neg_y_d;
  logic [blr_pkg::ERRW-1:0] err_q, err_d;
  logic [blr_pkg::CW-1:0]   color_q, color_d;
  logic                     show_q, show_d;
  logic                     busy_q, busy_d;

  logic                     ovalid_q, ovalid_d;
  logic [blr_pkg::XW-1:0]   ox_q;
  logic [blr_pkg::YW-1:0]   oy_q;
  logic [blr_pkg::CW-1:0]   ocolor_q;
  logic                     oshow_q, olast_q;

  logic                     out_free, is_tick, emit, at_goal, step_x, step_y;
  logic signed [blr_pkg::ERRW:0] e_ext, dx_ext, dy_ext, e_new;

  assign out_free = !ovalid_q || pixel_o.ready;
  assign is_tick  = (head_i.cmd.func == blr_pkg::FUNC_TICK);
  assign pop_o    = head_i.valid && (!is_tick || !busy_q || out_free);
  assign emit     = pop_o && is_tick && busy_q;
  assign at_goal  = (cur_x_q == goal_x_q) && (cur_y_q == goal_y_q);

  always_comb begin
    e_ext  = {err_q[blr_pkg::ERRW-1], err_q};
    dx_ext = $signed({{(blr_pkg::ERRW + 1 - blr_pkg::XW){1'b0}}, span_x_q});
    dy_ext = $signed({{(blr_pkg::ERRW + 1 - blr_pkg::YW){1'b0}}, span_y_q});
    step_x = e_ext > -dx_ext;
    step_y = e_ext < dy_ext;
    e_new  = e_ext - (step_x ? dy_ext : '0) + (step_y ? dx_ext : '0);
  end

  always_comb begin
    cur_x_d  = cur_x_q;
    cur_y_d  = cur_y_q;
    goal_x_d = goal_x_q;
    goal_y_d = goal_y_q;
    span_x_d = span_x_q;
    span_y_d = span_y_q;
    neg_x_d  = neg_x_q;
    neg_y_d  = neg_y_q;
    err_d    = err_q;
    color_d  = color_q;
    show_d   = show_q;
    busy_d   = busy_q;
    ovalid_d = pixel_o.ready ? 1'b0 : ovalid_q;
    if (pop_o && !is_tick) begin
      cur_x_d  = head_i.cmd.x0;
      cur_y_d  = head_i.cmd.y0;
      goal_x_d = head_i.cmd.x1;
      goal_y_d = head_i.cmd.y1;
      span_x_d = head_i.cmd.span_x;
      span_y_d = head_i.cmd.span_y;
      neg_x_d  = head_i.cmd.neg_x;
      neg_y_d  = head_i.cmd.neg_y;
      err_d    = head_i.cmd.err;
      color_d  = head_i.cmd.color;
      show_d   = head_i.cmd.show;
      busy_d   = 1'b1;
    end else if (emit) begin
      ovalid_d = 1'b1;
      if (at_goal) begin
        busy_d = 1'b0;
      end else begin
        err_d = e_new[blr_pkg::ERRW-1:0];
        if (step_x) cur_x_d = neg_x_q ? cur_x_q - 1'b1 : cur_x_q + 1'b1;
        if (step_y) cur_y_d = neg_y_q ? cur_y_q - 1'b1 : cur_y_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q  <= '0;
      cur_y_q  <= '0;
      goal_x_q <= '0;
      goal_y_q <= '0;
      span_x_q <= '0;
      span_y_q <= '0;
      neg_x_q  <= 1'b0;
      neg_y_q  <= 1'b0;
      err_q    <= '0;
      color_q  <= '0;
      show_q   <= 1'b0;
      busy_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      cur_x_q  <= cur_x_d;
      cur_y_q  <= cur_y_d;
      goal_x_q <= goal_x_d;
      goal_y_q <= goal_y_d;
      span_x_q <= span_x_d;
      span_y_q <= span_y_d;
      neg_x_q  <= neg_x_d;
      neg_y_q  <= neg_y_d;
      err_q    <= err_d;
      color_q  <= color_d;
      show_q   <= show_d;
      busy_q   <= busy_d;
      ovalid_q <= ovalid_d;
    end
  end

  // pixel payload
  always_ff @(posedge clk_i) begin
    if (emit) begin
      ox_q     <= cur_x_q;
      oy_q     <= cur_y_q;
      ocolor_q <= color_q;
      oshow_q  <= show_q;
      olast_q  <= at_goal;
    end
  end

  assign pixel_o.valid          = ovalid_q;
  assign pixel_o.pixel_x        = ox_q;
  assign pixel_o.pixel_y        = oy_q;
  assign pixel_o.pixel_color    = ocolor_q;
  assign pixel_o.pixel_show_now = oshow_q;
  assign pixel_o.last           = olast_q;

endmodule

/* hw/rtl/bresenham_line_rasterizer.sv */
// top level of the bresenham line rasterizer
`timescale 1ns / 1ps

// usage
// - item_i carries load beats (func low: endpoints, pen color, show flag) and
//   tick beats (func high); a load starts a new line and drops any old one
// - pixel_o gives one beat per tick while a line is running; the beat at the
//   second endpoint has last set, after which ticks give nothing
// - endpoints beyond the screen are saturated to the last column or row
// data path and throughput
// - a tick's pixel goes from the item queue via the pixel register to pixel_o
// - one item per clock sustained while pixel_o is ready: each pixel is two
//   compares, an add-subtract and up to two increments on the registered
//   error term and coordinates
// stalls and reset
// - a two-entry queue sits between the setup front and the stepping back;
//   the pixel register frees in the cycle it is taken, so items keep flowing
// - a stalled pixel beat holds; when the queue fills, item_i.ready drops
// - reset empties the queue and the pixel register and leaves no line active

module bresenham_line_rasterizer (
  input  logic        clk_i,
  input  logic        rst_ni,
  blr_item_if.sink    item_i,
  blr_pixel_if.source pixel_o
);

  // queue head toward the back part, and its pop
  blr_pkg::head_t head;
  logic           pop;

  blr_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (item_i),
    .pop_i  (pop),
    .head_o (head)
  );

  blr_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head),
    .pop_o   (pop),
    .pixel_o (pixel_o)
  );

`ifndef SYNTHESIS
  // the back never pops an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> head.valid)
    else $error("pop from empty queue");

  // a load at the head is always taken at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (head.valid && head.cmd.func == blr_pkg::FUNC_LOAD) |-> pop)
    else $error("load beat held at queue head");

  // a beat into an empty queue shows at the head next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (item_i.valid && item_i.ready && !head.valid) |=> head.valid)
    else $error("accepted beat lost in queue");
`endif

endmodule

/* tb/sv/line_pixel_checker.sv */
// checker that predicts and compares the pixel beats of the line rasterizer
`timescale 1ns / 1ps

module line_pixel_checker (
  input  logic clk_i,
  input  logic rst_ni,
  blr_item_if  item,
  blr_pixel_if pixel,
  output int   fail_count_o,
  output int   pending_o
);

  typedef struct packed {
    logic [blr_pkg::XW-1:0] x;
    logic [blr_pkg::YW-1:0] y;
    logic [blr_pkg::CW-1:0] color;
    logic                   show;
    logic                   last;
  } pixel_t;

  // own copy of the line state
  logic [blr_pkg::XW-1:0]          cur_x, goal_x, span_x;
  logic [blr_pkg::YW-1:0]          cur_y, goal_y, span_y;
  logic                            neg_x, neg_y;
  logic signed [blr_pkg::ERRW-1:0] err;
  logic [blr_pkg::CW-1:0]          held_color;
  logic                            held_show;
  logic                            line_active;

  pixel_t pixel_queue[$];
  int     failures;
  int     pixel_beats;

  task automatic report(string msg);
    failures++;
    $display("error: beat %0d: %s at %0t", pixel_beats, msg, $time);
  endtask

  // walk the line one item further, queueing the pixel a tick gives
  task automatic trace_item(logic func, logic [blr_pkg::XW-1:0] xs,
                            logic [blr_pkg::YW-1:0] ys,
                            logic [blr_pkg::XW-1:0] xe, logic [blr_pkg::YW-1:0] ye,
                            logic [blr_pkg::CW-1:0] color, logic show);
    int                     dx, dy, e, e2;
    logic [blr_pkg::XW-1:0] x0, x1;
    logic [blr_pkg::YW-1:0] y0, y1;
    pixel_t                 px;
    if (func == blr_pkg::FUNC_LOAD) begin
      // endpoints off screen saturate to the last column or row
      x0 = (int'(xs) > blr_pkg::SCREEN_WIDTH - 1) ?
           blr_pkg::XW'(blr_pkg::SCREEN_WIDTH - 1) : xs;
      x1 = (int'(xe) > blr_pkg::SCREEN_WIDTH - 1) ?
           blr_pkg::XW'(blr_pkg::SCREEN_WIDTH - 1) : xe;
      y0 = (int'(ys) > blr_pkg::SCREEN_HEIGHT - 1) ?
           blr_pkg::YW'(blr_pkg::SCREEN_HEIGHT - 1) : ys;
      y1 = (int'(ye) > blr_pkg::SCREEN_HEIGHT - 1) ?
           blr_pkg::YW'(blr_pkg::SCREEN_HEIGHT - 1) : ye;
      cur_x  = x0;
      cur_y  = y0;
      goal_x = x1;
      goal_y = y1;
      span_x = (x1 >= x0) ? x1 - x0 : x0 - x1;
      span_y = (y1 >= y0) ? y1 - y0 : y0 - y1;
      neg_x  = !(x0 < x1);
      neg_y  = !(y0 < y1);
      dx = int'(span_x);
      dy = int'(span_y);
      err = blr_pkg::ERRW'(dx > dy ? dx / 2 : -(dy / 2));
      held_color  = color;
      held_show   = show;
      line_active = 1'b1;
    end else if (line_active) begin
      px.x     = cur_x;
      px.y     = cur_y;
      px.color = held_color;
      px.show  = held_show;
      px.last  = 1'b0;
      if (cur_x == goal_x && cur_y == goal_y) begin
        px.last     = 1'b1;
        line_active = 1'b0;
      end else begin
        dx = int'(span_x);
        dy = int'(span_y);
        e  = int'(err);
        e2 = e;
        if (e2 > -dx) begin
          e -= dy;
          cur_x = neg_x ? cur_x - 1'b1 : cur_x + 1'b1;
        end
        if (e2 < dy) begin
          e += dx;
          cur_y = neg_y ? cur_y - 1'b1 : cur_y + 1'b1;
        end
        err = blr_pkg::ERRW'(e);
      end
      pixel_queue.push_back(px);
    end
  endtask

  task automatic check_pixel();
    pixel_t want;
    pixel_beats++;
    if (pixel_queue.size() == 0) begin
      report($sformatf("pixel beat (%0d,%0d) with nothing expected",
                       pixel.pixel_x, pixel.pixel_y));
      return;
    end
    want = pixel_queue.pop_front();
    if (pixel.pixel_x !== want.x)
      report($sformatf("pixel_x got %0h want %0h", pixel.pixel_x, want.x));
    if (pixel.pixel_y !== want.y)
      report($sformatf("pixel_y got %0h want %0h", pixel.pixel_y, want.y));
    if (pixel.pixel_color !== want.color)
      report($sformatf("pixel_color got %0h want %0h", pixel.pixel_color, want.color));
    if (pixel.pixel_show_now !== want.show)
      report($sformatf("pixel_show_now got %0h want %0h", pixel.pixel_show_now, want.show));
    if (pixel.last !== want.last)
      report($sformatf("last got %0h want %0h", pixel.last, want.last));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x = '0;
      cur_y = '0;
      goal_x = '0;
      goal_y = '0;
      span_x = '0;
      span_y = '0;
      neg_x = 1'b0;
      neg_y = 1'b0;
      err = '0;
      held_color = '0;
      held_show = 1'b0;
      line_active = 1'b0;
      pixel_queue.delete();
      failures = 0;
      pixel_beats = 0;
      pending_o <= 0;
      fail_count_o <= 0;
    end else begin
      if (item.valid && item.ready)
        trace_item(item.func, item.x_start, item.y_start, item.x_end, item.y_end,
                   item.pen_color, item.show_now);
      if (pixel.valid && pixel.ready) check_pixel();
      pending_o <= pixel_queue.size();
      fail_count_o <= failures;
    end
  end

endmodule

/* tb/sv/bresenham_line_rasterizer_test.sv */
// top of the line rasterizer testbench: stimulus, receiver, watchdog and verdict
`timescale 1ns / 1ps

module bresenham_line_rasterizer_test;

  // quiet cycles allowed before the run is declared hung; a correct run never
  // comes near this since every cycle either moves a beat or is a random stall
  localparam int STALL_LIMIT = 4000;
  // item beats per random idling phase; with the directed part and the last
  // line of each phase running over, the run sends at least 323 items
  localparam int PHASE_ITEMS = 100;

  logic clk_i;
  logic rst_ni;

  blr_item_if  item_ch();
  blr_pixel_if pixel_ch();

  int fail_count;
  int pending_pixels;
  int sender_idle_pct   = 14;
  int receiver_idle_pct = 54;
  int quiet_cycles      = 0;
  int items_sent        = 0;
  int phase_start;

  bresenham_line_rasterizer DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_ch),
    .pixel_o (pixel_ch)
  );

  line_pixel_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item         (item_ch),
    .pixel        (pixel_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending_pixels)
  );

  // 12 ns clock
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // pixel receiver: stalls at random with the current idling rate
  initial begin
    pixel_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      pixel_ch.ready <= (int'($urandom_range(99)) >= receiver_idle_pct);
    end
  end

  // watchdog: ends the run when no beat moves on either channel for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (item_ch.valid && item_ch.ready) || (pixel_ch.valid && pixel_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // one item beat; the sender may idle first, then holds the beat until taken
  task automatic send_item(logic func, logic [blr_pkg::XW-1:0] xs,
                           logic [blr_pkg::YW-1:0] ys,
                           logic [blr_pkg::XW-1:0] xe, logic [blr_pkg::YW-1:0] ye,
                           logic [blr_pkg::CW-1:0] color, logic show);
    while (int'($urandom_range(99)) < sender_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    item_ch.valid     <= 1'b1;
    item_ch.func      <= func;
    item_ch.x_start   <= xs;
    item_ch.y_start   <= ys;
    item_ch.x_end     <= xe;
    item_ch.y_end     <= ye;
    item_ch.pen_color <= color;
    item_ch.show_now  <= show;
    do @(posedge clk_i); while (!item_ch.ready);
    items_sent++;
  endtask

  // tick beat; its endpoint fields are junk the block must ignore
  task automatic send_tick();
    send_item(blr_pkg::FUNC_TICK, blr_pkg::XW'($urandom), blr_pkg::YW'($urandom),
              blr_pkg::XW'($urandom), blr_pkg::YW'($urandom),
              blr_pkg::CW'($urandom), 1'($urandom));
  endtask

  // a load with random pen, mostly short lines near the start point so that
  // many lines run to their end, now and then a fully random one
  task automatic random_line();
    logic [blr_pkg::XW-1:0] xs, xe;
    logic [blr_pkg::YW-1:0] ys, ye;
    int                     t, span_x, span_y, pixels, n;
    xs = blr_pkg::XW'($urandom);
    ys = blr_pkg::YW'($urandom);
    if ($urandom_range(7) == 0) begin
      xe = blr_pkg::XW'($urandom);
      ye = blr_pkg::YW'($urandom);
    end else begin
      t = int'(xs) + int'($urandom_range(24)) - 12;
      xe = (t < 0) ? '0 : (t > blr_pkg::SCREEN_WIDTH - 1) ?
           blr_pkg::XW'(blr_pkg::SCREEN_WIDTH - 1) : blr_pkg::XW'(t);
      t = int'(ys) + int'($urandom_range(16)) - 8;
      ye = (t < 0) ? '0 : (t > blr_pkg::SCREEN_HEIGHT - 1) ?
           blr_pkg::YW'(blr_pkg::SCREEN_HEIGHT - 1) : blr_pkg::YW'(t);
    end
    span_x = (xe >= xs) ? int'(xe - xs) : int'(xs - xe);
    span_y = (ye >= ys) ? int'(ye - ys) : int'(ys - ye);
    pixels = ((span_x > span_y) ? span_x : span_y) + 1;
    send_item(blr_pkg::FUNC_LOAD, xs, ys, xe, ye, blr_pkg::CW'($urandom), 1'($urandom));
    // mostly run the line out and a little past it, sometimes cut it short
    // so that the next load drops it
    if ($urandom_range(4) == 0) n = int'($urandom_range(pixels));
    else n = pixels + int'($urandom_range(2));
    repeat (n) send_tick();
  endtask

  // hold the sender off until every expected pixel has come out
  task automatic drain_pixels();
    item_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending_pixels != 0);
  endtask

  initial begin
    rst_ni            <= 1'b0;
    item_ch.valid     <= 1'b0;
    item_ch.func      <= blr_pkg::FUNC_TICK;
    item_ch.x_start   <= '0;
    item_ch.y_start   <= '0;
    item_ch.x_end     <= '0;
    item_ch.y_end     <= '0;
    item_ch.pen_color <= '0;
    item_ch.show_now  <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: tick while idle after reset gives nothing
    send_tick();
    // full-screen diagonal at field extremes, cut short by a reload
    send_item(blr_pkg::FUNC_LOAD, 8'd0, 6'd0, 8'd255, 6'd63, 4'd15, 1'b1);
    repeat (2) send_tick();
    send_item(blr_pkg::FUNC_LOAD, 8'd255, 6'd63, 8'd0, 6'd0, 4'd0, 1'b0);
    repeat (2) send_tick();
    // equal endpoints: single pixel marked last, then an idle tick
    send_item(blr_pkg::FUNC_LOAD, 8'd10, 6'd20, 8'd10, 6'd20, 4'd5, 1'b1);
    repeat (2) send_tick();
    // shallow line stepping left and down
    send_item(blr_pkg::FUNC_LOAD, 8'd200, 6'd5, 8'd196, 6'd7, 4'd10, 1'b0);
    repeat (5) send_tick();
    // steep line stepping up and right
    send_item(blr_pkg::FUNC_LOAD, 8'd3, 6'd60, 8'd4, 6'd55, 4'd9, 1'b1);
    repeat (6) send_tick();
    drain_pixels();

    // random phases: quick sender / busy receiver, swapped, then no idling
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          sender_idle_pct   = 14;
          receiver_idle_pct = 54;
        end
        1: begin
          sender_idle_pct   = 54;
          receiver_idle_pct = 14;
        end
        default: begin
          sender_idle_pct   = 0;
          receiver_idle_pct = 0;
        end
      endcase
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        // occasional stray tick as noise
        if ($urandom_range(9) == 0) send_tick();
        random_line();
      end
      drain_pixels();
    end

    // let the clock run on so that any stray pixel beat gets caught
    repeat (16) @(posedge clk_i);
    if (fail_count == 0 && pending_pixels == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
